/* sv/lmsd_pkg.sv */
package lmsd_pkg;

   // Field widths of a request and a response
   localparam int KIND_W    = 3;
   localparam int IMAGE_W   = 25;
   localparam int COORD_W   = 3;
   localparam int ROW_W     = 9;
   localparam int COL_W     = 3;
   localparam int CYCLE_W   = 2;
   localparam int PIX_W     = 5;

   // Matrix geometry
   localparam int NUM_COLS   = 3;
   localparam int IMAGE_SIDE = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 3'd0,
      KIND_OR     = 3'd1,
      KIND_CLEAR  = 3'd2,
      KIND_PLOT   = 3'd3,
      KIND_UNPLOT = 3'd4
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [IMAGE_W-1:0] or_bits;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_levels;
      logic [COL_W-1:0] col_levels;
      logic             drive_enable;
      logic             scanned;
   } rsp_item_type;

   // Input stage towards the scan core
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   // Pixel number (1..25) on row lines 1..9 of each column; 0 = row unused
   typedef logic [PIX_W-1:0] pix_row_type [0:ROW_W-1];
   typedef pix_row_type pix_map_type [0:NUM_COLS-1];

   localparam pix_map_type PIX_MAP = '{
      '{5'd1,  5'd3,  5'd12, 5'd16, 5'd17, 5'd5,  5'd20, 5'd19, 5'd18},
      '{5'd15, 5'd11, 5'd0,  5'd0,  5'd22, 5'd13, 5'd2,  5'd4,  5'd24},
      '{5'd23, 5'd25, 5'd14, 5'd10, 5'd9,  5'd21, 5'd6,  5'd7,  5'd8}
   };

   // Row levels for one column: lit pixel pulls its row low
   function automatic logic [ROW_W-1:0] row_levels_for(
      input logic [CYCLE_W-1:0] col,
      input logic [IMAGE_W-1:0] snap
   );
      logic [ROW_W-1:0] rows;
      logic [PIX_W-1:0] p;
      rows = '1;
      for (int r = 0; r < ROW_W; r++) begin
         p = PIX_MAP[col][r];
         if (p != '0 && snap[PIX_W'(p - 5'd1)]) begin
            rows[r] = 1'b0;
         end
      end
      return rows;
   endfunction

endpackage

/* sv/lmsd_if.sv */
// Request channel: one image operation or scan tick
interface lmsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lmsd_pkg::KIND_W-1:0]   kind;
   logic [lmsd_pkg::IMAGE_W-1:0]  or_bits;
   logic [lmsd_pkg::COORD_W-1:0]  pixel_x;
   logic [lmsd_pkg::COORD_W-1:0]  pixel_y;

   modport source (output valid, kind, or_bits, pixel_x, pixel_y, input ready);
   modport sink   (input valid, kind, or_bits, pixel_x, pixel_y, output ready);
endinterface

// Response channel: line levels after each request
interface lmsd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lmsd_pkg::ROW_W-1:0]   row_levels;
   logic [lmsd_pkg::COL_W-1:0]   col_levels;
   logic                         drive_enable;
   logic                         scanned;

   modport source (output valid, row_levels, col_levels, drive_enable, scanned,
                   input ready);
   modport sink   (input valid, row_levels, col_levels, drive_enable, scanned,
                   output ready);
endinterface

/* sv/lmsd_in_stage.sv */
// Input register: holds one request until the scan core takes it
module lmsd_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lmsd_pkg::req_item_type req_item,
   input  logic                   take,
   output lmsd_pkg::stage_type    stage
);

   logic                   valid_ff, valid_in;
   lmsd_pkg::req_item_type item_ff, item_in;

   // free when empty or emptying this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

/* sv/lmsd_core.sv */
// Scan core: image and scan state, one request per cycle into the result register while it is empty or drained
module lmsd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  lmsd_pkg::stage_type    stage,
   output logic                   take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lmsd_pkg::rsp_item_type rsp_item
);

   logic [lmsd_pkg::IMAGE_W-1:0] image_ff, image_in;
   logic [lmsd_pkg::IMAGE_W-1:0] snap_ff, snap_in;
   logic [lmsd_pkg::CYCLE_W-1:0] cycle_ff, cycle_in;
   logic [lmsd_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [lmsd_pkg::COL_W-1:0]   col_ff, col_in;
   logic                         drive_ff, drive_in;
   logic                         out_valid_ff, out_valid_in;
   lmsd_pkg::rsp_item_type       out_item_ff, out_item_in;

   logic                         scanned;
   logic                         scan_go;
   logic                         px_ok;
   logic [lmsd_pkg::PIX_W-1:0]   px_shift;
   logic [lmsd_pkg::IMAGE_W-1:0] px_mask;
   logic [lmsd_pkg::COORD_W-1:0] px_x, px_y;

   // advance when the result register is empty or being drained
   assign take = stage.valid && (!out_valid_ff || rsp_ready);

   // pixel bit: 5*(y-1)+(x-1), only for x and y in 1..5
   assign px_x     = stage.item.pixel_x;
   assign px_y     = stage.item.pixel_y;
   assign px_ok    = px_x != '0 && px_x <= lmsd_pkg::COORD_W'(lmsd_pkg::IMAGE_SIDE)
                  && px_y != '0 && px_y <= lmsd_pkg::COORD_W'(lmsd_pkg::IMAGE_SIDE);
   assign px_shift = lmsd_pkg::PIX_W'(({2'b00, px_y} - 5'd1) * 5'd5
                                      + {2'b00, px_x} - 5'd1);
   assign px_mask  = lmsd_pkg::IMAGE_W'(1) << px_shift;

   // state update for the request in the input register
   always_comb begin
      image_in = image_ff;
      snap_in  = snap_ff;
      cycle_in = cycle_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      drive_in = drive_ff;
      scanned  = 1'b0;
      scan_go  = 1'b0;
      if (take) begin
         case (lmsd_pkg::kind_type'(stage.item.kind))
            lmsd_pkg::KIND_TICK: begin
               if (image_ff != '0 || snap_ff != '0) begin
                  scan_go = 1'b1;
                  // start of a column cycle: snapshot, or blank the display
                  if (cycle_ff == '0) begin
                     if (snap_ff != '0 && image_ff == '0) begin
                        snap_in  = '0;
                        drive_in = 1'b0;
                        scan_go  = 1'b0;
                     end else begin
                        if (snap_ff == '0) begin
                           drive_in = 1'b1;
                        end
                        snap_in = image_ff;
                     end
                  end
                  if (scan_go) begin
                     scanned = 1'b1;
                     if (cycle_ff == lmsd_pkg::CYCLE_W'(lmsd_pkg::NUM_COLS)) begin
                        col_in   = '0;
                        cycle_in = '0;
                     end else begin
                        row_in   = lmsd_pkg::row_levels_for(cycle_ff, snap_in);
                        col_in   = lmsd_pkg::COL_W'(1) << cycle_ff;
                        cycle_in = (cycle_ff == lmsd_pkg::CYCLE_W'(lmsd_pkg::NUM_COLS - 1))
                                 ? '0 : cycle_ff + 2'd1;
                     end
                  end
               end
            end
            lmsd_pkg::KIND_OR: begin
               image_in = image_ff | stage.item.or_bits;
            end
            lmsd_pkg::KIND_CLEAR: begin
               image_in = '0;
            end
            lmsd_pkg::KIND_PLOT: begin
               if (px_ok) begin
                  image_in = image_ff | px_mask;
               end
            end
            lmsd_pkg::KIND_UNPLOT: begin
               if (px_ok) begin
                  image_in = image_ff & ~px_mask;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_comb begin
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in              = 1'b1;
         out_item_in.row_levels    = row_in;
         out_item_in.col_levels    = col_in;
         out_item_in.drive_enable  = drive_in;
         out_item_in.scanned       = scanned;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff     <= '0;
         snap_ff      <= '0;
         cycle_ff     <= '0;
         row_ff       <= '1;
         col_ff       <= '0;
         drive_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         image_ff     <= image_in;
         snap_ff      <= snap_in;
         cycle_ff     <= cycle_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         drive_ff     <= drive_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

/* sv/led_matrix_scan_driver.sv */
// Channel   Dir  Handshake          Payload
// req_ch    in   valid/ready        kind, or_bits, pixel_x, pixel_y
// rsp_ch    out  valid/ready        row_levels, col_levels, drive_enable, scanned
//
// One request per clock while responses are taken: an input register feeds a single
// pass of update logic whose outcome lands in a result register.
// Every request gives exactly one response, in order.
// Synchronous reset clears the image, snapshot and scan state; rows reset high.
// A stalled response holds the result register; req_ch.ready then drops only once
// the input register is also full.
module led_matrix_scan_driver (
   input  logic        clock,
   input  logic        reset,
   lmsd_req_if.sink    req_ch,
   lmsd_rsp_if.source  rsp_ch
);

   lmsd_pkg::req_item_type req_item;
   lmsd_pkg::rsp_item_type rsp_item;
   lmsd_pkg::stage_type    stage;
   logic                   take;

   assign req_item.kind    = req_ch.kind;
   assign req_item.or_bits = req_ch.or_bits;
   assign req_item.pixel_x = req_ch.pixel_x;
   assign req_item.pixel_y = req_ch.pixel_y;

   lmsd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_item  (req_item),
      .take      (take),
      .stage     (stage)
   );

   lmsd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .take      (take),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_ch.row_levels   = rsp_item.row_levels;
   assign rsp_ch.col_levels   = rsp_item.col_levels;
   assign rsp_ch.drive_enable = rsp_item.drive_enable;
   assign rsp_ch.scanned      = rsp_item.scanned;

endmodule

/* dv/led_matrix_scan_driver_tb.sv */
`timescale 1ns / 1ps

module led_matrix_scan_driver_tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int GAP_MAX      = 17;
   localparam int KIND_MAX     = (1 << lmsd_pkg::KIND_W) - 1;
   localparam int KIND_BAD_LO  = lmsd_pkg::KIND_UNPLOT + 1;

   logic clock;
   logic reset;

   lmsd_req_if req_if ();
   lmsd_rsp_if rsp_if ();

   led_matrix_scan_driver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Shadow of the scan state
   logic [lmsd_pkg::IMAGE_W-1:0] img;
   logic [lmsd_pkg::IMAGE_W-1:0] snap;
   logic [lmsd_pkg::CYCLE_W-1:0] cyc;
   logic [lmsd_pkg::ROW_W-1:0]   row_lv;
   logic [lmsd_pkg::COL_W-1:0]   col_lv;
   logic                         drv;

   lmsd_pkg::rsp_item_type lines_expected[$];
   int                     n_errors;
   int                     idle_cycles;
   int                     req_gap_max;
   int                     rsp_gap_max;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Line levels after one request; updates the shadow state
   function automatic lmsd_pkg::rsp_item_type predict_lines(input lmsd_pkg::req_item_type r);
      lmsd_pkg::rsp_item_type     o;
      logic                       scan;
      logic [lmsd_pkg::ROW_W-1:0] rows;
      logic [lmsd_pkg::PIX_W-1:0] p;
      int                         pos;
      scan = 1'b0;
      case (r.kind)
         lmsd_pkg::KIND_TICK: begin
            if (img != '0 || snap != '0) begin
               scan = 1'b1;
               // start of a column cycle: switch on, switch off, or reload
               if (cyc == '0) begin
                  if (img == '0) begin
                     snap = '0;
                     drv  = 1'b0;
                     scan = 1'b0;
                  end else begin
                     if (snap == '0) drv = 1'b1;
                     snap = img;
                  end
               end
               if (scan) begin
                  if (cyc >= lmsd_pkg::NUM_COLS) begin
                     col_lv = '0;
                     cyc    = '0;
                  end else begin
                     rows = '1;
                     for (int i = 0; i < lmsd_pkg::ROW_W; i++) begin
                        p = lmsd_pkg::PIX_MAP[cyc][i];
                        if (p != '0 && snap[p - 1]) rows[i] = 1'b0;
                     end
                     row_lv = rows;
                     col_lv = lmsd_pkg::COL_W'(1) << cyc;
                     cyc    = lmsd_pkg::CYCLE_W'((int'(cyc) + 1) % lmsd_pkg::NUM_COLS);
                  end
               end
            end
         end
         lmsd_pkg::KIND_OR:    img = img | r.or_bits;
         lmsd_pkg::KIND_CLEAR: img = '0;
         lmsd_pkg::KIND_PLOT, lmsd_pkg::KIND_UNPLOT: begin
            if (r.pixel_x >= 1 && r.pixel_x <= lmsd_pkg::IMAGE_SIDE &&
                r.pixel_y >= 1 && r.pixel_y <= lmsd_pkg::IMAGE_SIDE) begin
               pos = lmsd_pkg::IMAGE_SIDE * (int'(r.pixel_y) - 1) + (int'(r.pixel_x) - 1);
               img[pos] = (r.kind == lmsd_pkg::KIND_PLOT);
            end
         end
         default: ;
      endcase
      o.row_levels   = row_lv;
      o.col_levels   = col_lv;
      o.drive_enable = drv;
      o.scanned      = scan;
      return o;
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, exp_v,
                  act_v);
         n_errors++;
      end
   endfunction

   // Monitor: predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      lmsd_pkg::rsp_item_type e;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (lines_expected.size() == 0) begin
               $display("%0t: response with nothing expected, actual %h/%h/%b/%b", $time,
                        rsp_if.row_levels, rsp_if.col_levels, rsp_if.drive_enable,
                        rsp_if.scanned);
               n_errors++;
            end else begin
               e = lines_expected.pop_front();
               check_field("row_levels", e.row_levels, rsp_if.row_levels);
               check_field("col_levels", e.col_levels, rsp_if.col_levels);
               check_field("drive_enable", e.drive_enable, rsp_if.drive_enable);
               check_field("scanned", e.scanned, rsp_if.scanned);
            end
         end
         if (req_if.valid && req_if.ready) begin
            lines_expected.push_back(predict_lines('{kind:    req_if.kind,
                                                      or_bits: req_if.or_bits,
                                                      pixel_x: req_if.pixel_x,
                                                      pixel_y: req_if.pixel_y}));
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
         $display("led_matrix_scan_driver_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random stall before each response
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready && !reset));
         @(negedge clock);
      end
   end

   // Send one request; entered and left at a falling edge
   task automatic send_req(input logic [lmsd_pkg::KIND_W-1:0] kind,
                           input logic [lmsd_pkg::IMAGE_W-1:0] bits,
                           input logic [lmsd_pkg::COORD_W-1:0] x,
                           input logic [lmsd_pkg::COORD_W-1:0] y);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.kind    <= kind;
      req_if.or_bits <= bits;
      req_if.pixel_x <= x;
      req_if.pixel_y <= y;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Ticks and unknown kinds on a blank display
   task automatic test_blank_ticks();
      req_gap_max = 0;
      rsp_gap_max = 0;
      send_req(lmsd_pkg::KIND_TICK, '0, '0, '0);
      send_req(lmsd_pkg::KIND_TICK, '1, '1, '1);
      for (int k = KIND_BAD_LO; k <= KIND_MAX; k++) begin
         send_req(lmsd_pkg::KIND_W'(k), '1, 3'd1, 3'd1);
      end
   endtask

   // All pixels on, a full column cycle and a reload
   task automatic test_full_image();
      req_gap_max = GAP_MAX;
      rsp_gap_max = GAP_MAX;
      send_req(lmsd_pkg::KIND_OR, '1, '0, '0);
      repeat (4) send_req(lmsd_pkg::KIND_TICK, '0, '0, '0);
      send_req(lmsd_pkg::KIND_OR, '0, '0, '0);
   endtask

   // Plot and unplot at the corners and out of range
   task automatic test_pixel_ops();
      logic [lmsd_pkg::COORD_W-1:0] side;
      side = lmsd_pkg::COORD_W'(lmsd_pkg::IMAGE_SIDE);
      req_gap_max = 3;
      rsp_gap_max = GAP_MAX;
      send_req(lmsd_pkg::KIND_CLEAR, '0, '0, '0);
      send_req(lmsd_pkg::KIND_PLOT, '0, 3'd1, 3'd1);
      send_req(lmsd_pkg::KIND_PLOT, '0, side, side);
      send_req(lmsd_pkg::KIND_PLOT, '0, 3'd0, 3'd3);
      send_req(lmsd_pkg::KIND_PLOT, '0, side + 3'd1, 3'd1);
      send_req(lmsd_pkg::KIND_PLOT, '1, '1, '1);
      send_req(lmsd_pkg::KIND_UNPLOT, '0, side, side);
      send_req(lmsd_pkg::KIND_UNPLOT, '0, 3'd3, 3'd0);
      send_req(lmsd_pkg::KIND_TICK, '0, '0, '0);
      send_req(lmsd_pkg::KIND_TICK, '0, '0, '0);
   endtask

   // Blank image: finish the cycle, then the drive switches off
   task automatic test_blanking();
      req_gap_max = GAP_MAX;
      rsp_gap_max = 0;
      send_req(lmsd_pkg::KIND_CLEAR, '1, '1, '1);
      repeat (4) send_req(lmsd_pkg::KIND_TICK, '0, '0, '0);
   endtask

   // Ticks for half the items among image edits, with the idle pattern changed per phase
   task automatic test_random_ops(input int n_items);
      lmsd_pkg::req_item_type it;
      int                     sel;
      for (int n = 0; n < n_items; n++) begin
         if (n % 50 == 0) begin
            sel = $urandom_range(0, 3);
            req_gap_max = (sel == 0) ? 0 : (sel == 1) ? GAP_MAX : $urandom_range(0, GAP_MAX);
            sel = $urandom_range(0, 3);
            rsp_gap_max = (sel == 0) ? 0 : (sel == 1) ? GAP_MAX : $urandom_range(0, GAP_MAX);
         end
         it.or_bits = lmsd_pkg::IMAGE_W'($urandom);
         it.pixel_x = lmsd_pkg::COORD_W'($urandom);
         it.pixel_y = lmsd_pkg::COORD_W'($urandom);
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            it.kind = lmsd_pkg::KIND_TICK;
         end else if (sel < 60) begin
            it.kind = lmsd_pkg::KIND_OR;
            case ($urandom_range(0, 3))
               0: it.or_bits = lmsd_pkg::IMAGE_W'(1)
                               << $urandom_range(0, lmsd_pkg::IMAGE_W - 1);
               1: it.or_bits = '1;
               2: it.or_bits = '0;
               default: ;
            endcase
         end else if (sel < 66) begin
            it.kind = lmsd_pkg::KIND_CLEAR;
         end else if (sel < 94) begin
            it.kind = (sel < 80) ? lmsd_pkg::KIND_PLOT : lmsd_pkg::KIND_UNPLOT;
            // mostly on the grid, sometimes off it
            if ($urandom_range(0, 9) != 0) begin
               it.pixel_x = lmsd_pkg::COORD_W'($urandom_range(1, lmsd_pkg::IMAGE_SIDE));
               it.pixel_y = lmsd_pkg::COORD_W'($urandom_range(1, lmsd_pkg::IMAGE_SIDE));
            end
         end else begin
            it.kind = lmsd_pkg::KIND_W'($urandom_range(KIND_BAD_LO, KIND_MAX));
         end
         send_req(it.kind, it.or_bits, it.pixel_x, it.pixel_y);
      end
   endtask

   // Main sequence
   initial begin
      n_errors       = 0;
      idle_cycles    = 0;
      req_gap_max    = 0;
      rsp_gap_max    = 0;
      img            = '0;
      snap           = '0;
      cyc            = '0;
      row_lv         = '1;
      col_lv         = '0;
      drv            = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.kind    = '0;
      req_if.or_bits = '0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_blank_ticks();
      test_full_image();
      test_pixel_ops();
      test_blanking();
      test_random_ops(1100);

      req_if.valid <= 1'b0;
      while (lines_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (lines_expected.size() != 0) n_errors++;

      if (n_errors == 0) begin
         $display("led_matrix_scan_driver_tb OK");
      end else begin
         $display("led_matrix_scan_driver_tb NOT OK");
      end
      $finish;
   end

endmodule
